@@ hdl/pav_pkg.sv @@
// ============================================================================
// pav_pkg: shared types and constants for the point axis rotator
// Holds the command codes, the lane modes, the trig unit states and the Q16
// constants of the sine/cosine unit.
// ============================================================================
package pav_pkg;

    // Width of the Q16 sine and cosine values (+/-1.0 needs 18 signed bits)
    localparam int TRIG_W = 18;

    // Q16 constants
    localparam int Q_ONE       = 65536;
    localparam int Q_PI        = 205887;
    localparam int Q_TWO_PI    = 411775;
    localparam int Q_HALF_PI   = 102944;
    localparam int CORDIC_GAIN = 39797;

    localparam int CORDIC_STEPS = 17;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);

    // Width of the working values inside the CORDIC
    localparam int CORDIC_W = 20;

    // Command codes
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_X_POS = 3'd1;
    localparam logic [2:0] CMD_X_NEG = 3'd2;
    localparam logic [2:0] CMD_Y_NEG = 3'd3;
    localparam logic [2:0] CMD_Y_POS = 3'd4;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_ROT_X,
        MODE_ROT_Y
    } lane_mode_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_FOLD,
        CS_ITER
    } cordic_state_t;

    // Trig unit to datapath
    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_q;
        logic signed [TRIG_W-1:0] sin_q;
        logic                     zero;
        logic                     busy;
    } trig_t;

    // atan(2^-i) in Q16
    function automatic logic [16:0] atan_q16(input logic [ITER_W-1:0] idx);
        logic [16:0] r;
        begin
            case (idx)
                5'd0:    r = 17'd51472;
                5'd1:    r = 17'd30386;
                5'd2:    r = 17'd16055;
                5'd3:    r = 17'd8150;
                5'd4:    r = 17'd4091;
                5'd5:    r = 17'd2047;
                5'd6:    r = 17'd1024;
                5'd7:    r = 17'd512;
                5'd8:    r = 17'd256;
                5'd9:    r = 17'd128;
                5'd10:   r = 17'd64;
                5'd11:   r = 17'd32;
                5'd12:   r = 17'd16;
                5'd13:   r = 17'd8;
                5'd14:   r = 17'd4;
                5'd15:   r = 17'd2;
                5'd16:   r = 17'd1;
                default: r = 17'd0;
            endcase
            return r;
        end
    endfunction

endpackage

@@ hdl/pav_cordic.sv @@
// ============================================================================
// pav_cordic: sine and cosine of the step angle
// Folds the written angle into [-pi/2, pi/2] one step a cycle, then runs a
// 17-step shift-add CORDIC and holds the Q16 sine and cosine.
// ============================================================================
module pav_cordic #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [15:0]    cfg_wr_data,
    output pav_pkg::trig_t trig
);
    import pav_pkg::*;

    localparam int SHIFT = 16 - ANGLE_FRAC_BITS;
    localparam int AW    = 36 - ANGLE_FRAC_BITS;

    localparam logic signed [AW-1:0] PI_A      = AW'(Q_PI);
    localparam logic signed [AW-1:0] TWO_PI_A  = AW'(Q_TWO_PI);
    localparam logic signed [AW-1:0] HALF_PI_A = AW'(Q_HALF_PI);
    localparam logic signed [CORDIC_W-1:0] GAIN_C = CORDIC_W'(CORDIC_GAIN);
    localparam logic signed [TRIG_W-1:0]   ONE_T  = TRIG_W'(Q_ONE);

    cordic_state_t state_reg, state_next;
    logic signed [AW-1:0]       angle_reg, angle_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic [ITER_W-1:0]          iter_reg, iter_next;
    logic                       neg_reg, neg_next;
    logic                       zero_reg, zero_next;
    logic signed [TRIG_W-1:0]   cos_reg, cos_next;
    logic signed [TRIG_W-1:0]   sin_reg, sin_next;

    logic signed [CORDIC_W-1:0] x_sh, y_sh, x_step, y_step;
    logic signed [AW-1:0]       atan_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            zero_reg  <= 1'b1;
            cos_reg   <= ONE_T;
            sin_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            zero_reg  <= zero_next;
            cos_reg   <= cos_next;
            sin_reg   <= sin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        iter_reg  <= iter_next;
        neg_reg   <= neg_next;
    end

    always_comb
    begin
        x_sh   = x_reg >>> iter_reg;
        y_sh   = y_reg >>> iter_reg;
        atan_a = signed'({{(AW-17){1'b0}}, atan_q16(iter_reg)});

        state_next = state_reg;
        angle_next = angle_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        iter_next  = iter_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        cos_next   = cos_reg;
        sin_next   = sin_reg;
        x_step     = '0;
        y_step     = '0;

        unique case (state_reg)
            CS_IDLE:
            begin
            end
            CS_FOLD:
            begin
                // Wrap by 2pi one step a cycle, then bring into the right half
                if (angle_reg > PI_A)
                begin
                    angle_next = angle_reg - TWO_PI_A;
                end
                else if (angle_reg < -PI_A)
                begin
                    angle_next = angle_reg + TWO_PI_A;
                end
                else
                begin
                    if (angle_reg > HALF_PI_A)
                    begin
                        angle_next = angle_reg - PI_A;
                        neg_next   = 1'b1;
                    end
                    else if (angle_reg < -HALF_PI_A)
                    begin
                        angle_next = angle_reg + PI_A;
                        neg_next   = 1'b1;
                    end
                    else
                    begin
                        neg_next = 1'b0;
                    end
                    x_next     = GAIN_C;
                    y_next     = '0;
                    iter_next  = '0;
                    state_next = CS_ITER;
                end
            end
            CS_ITER:
            begin
                if (!angle_reg[AW-1])
                begin
                    x_step     = x_reg - y_sh;
                    y_step     = y_reg + x_sh;
                    angle_next = angle_reg - atan_a;
                end
                else
                begin
                    x_step     = x_reg + y_sh;
                    y_step     = y_reg - x_sh;
                    angle_next = angle_reg + atan_a;
                end
                x_next    = x_step;
                y_next    = y_step;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
                begin
                    cos_next   = neg_reg ? TRIG_W'(-x_step) : TRIG_W'(x_step);
                    sin_next   = neg_reg ? TRIG_W'(-y_step) : TRIG_W'(y_step);
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase

        // A register write restarts the unit
        if (cfg_wr_en)
        begin
            angle_next = AW'(signed'(cfg_wr_data)) <<< SHIFT;
            zero_next  = (cfg_wr_data == 16'd0);
            state_next = CS_FOLD;
        end
    end

    assign trig.cos_q = cos_reg;
    assign trig.sin_q = sin_reg;
    assign trig.zero  = zero_reg;
    assign trig.busy  = (state_reg != CS_IDLE);

endmodule

@@ hdl/pav_lane.sv @@
// ============================================================================
// pav_lane: rotation datapath for one point
// Stage one forms the four products, stage two sums, rounds and saturates
// them and holds the rotated point.
// ============================================================================
module pav_lane #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                               clk,
    input  logic                               load_mul,
    input  logic                               load_out,
    input  pav_pkg::lane_mode_t                mode,
    input  logic signed [pav_pkg::TRIG_W-1:0]  cos_q,
    input  logic signed [pav_pkg::TRIG_W-1:0]  sin_q,
    input  logic signed [COORD_WIDTH-1:0]      x,
    input  logic signed [COORD_WIDTH-1:0]      y,
    input  logic signed [COORD_WIDTH-1:0]      z,
    output logic signed [COORD_WIDTH-1:0]      rot_x,
    output logic signed [COORD_WIDTH-1:0]      rot_y,
    output logic signed [COORD_WIDTH-1:0]      rot_z
);
    import pav_pkg::*;

    localparam int PW = COORD_WIDTH + TRIG_W;
    localparam int SW = PW + 1;

    localparam logic signed [SW-1:0] ROUND_C = SW'(32768);
    localparam logic signed [SW-1:0] MAX_C   =
        {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] MIN_C   =
        {{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    lane_mode_t                   mode_reg;
    logic signed [COORD_WIDTH-1:0] x_reg, y_reg, z_reg;
    logic signed [PW-1:0]         prod_ac_reg, prod_bs_reg, prod_as_reg, prod_bc_reg;
    logic signed [COORD_WIDTH-1:0] rot_x_reg, rot_y_reg, rot_z_reg;
    logic signed [COORD_WIDTH-1:0] rot_x_next, rot_y_next, rot_z_next;

    logic signed [COORD_WIDTH-1:0] op_a, op_b;
    logic signed [SW-1:0]         sum_a, sum_b;
    logic signed [COORD_WIDTH-1:0] new_a, new_b;

    function automatic logic signed [COORD_WIDTH-1:0] round_sat(
        input logic signed [SW-1:0] acc
    );
        logic signed [SW-1:0] r;
        logic signed [COORD_WIDTH-1:0] q;
        begin
            r = (acc + ROUND_C) >>> 16;
            if (r > MAX_C)
            begin
                q = MAX_C[COORD_WIDTH-1:0];
            end
            else if (r < MIN_C)
            begin
                q = MIN_C[COORD_WIDTH-1:0];
            end
            else
            begin
                q = r[COORD_WIDTH-1:0];
            end
            return q;
        end
    endfunction

    // Pair (a, b) turns as a' = a*c - b*s, b' = a*s + b*c:
    // about x it is (y, z), about y it is (z, x).
    always_comb
    begin
        op_a = (mode == MODE_ROT_Y) ? z : y;
        op_b = (mode == MODE_ROT_Y) ? x : z;
    end

    always_ff @(posedge clk)
    begin
        if (load_mul)
        begin
            mode_reg    <= mode;
            x_reg       <= x;
            y_reg       <= y;
            z_reg       <= z;
            prod_ac_reg <= op_a * cos_q;
            prod_bs_reg <= op_b * sin_q;
            prod_as_reg <= op_a * sin_q;
            prod_bc_reg <= op_b * cos_q;
        end
    end

    always_comb
    begin
        sum_a = SW'(prod_ac_reg) - SW'(prod_bs_reg);
        sum_b = SW'(prod_as_reg) + SW'(prod_bc_reg);
        new_a = round_sat(sum_a);
        new_b = round_sat(sum_b);

        case (mode_reg)
            MODE_ROT_X:
            begin
                rot_x_next = x_reg;
                rot_y_next = new_a;
                rot_z_next = new_b;
            end
            MODE_ROT_Y:
            begin
                rot_x_next = new_b;
                rot_y_next = y_reg;
                rot_z_next = new_a;
            end
            default:
            begin
                rot_x_next = x_reg;
                rot_y_next = y_reg;
                rot_z_next = z_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rot_x_reg <= rot_x_next;
            rot_y_reg <= rot_y_next;
            rot_z_reg <= rot_z_next;
        end
    end

    assign rot_x = rot_x_reg;
    assign rot_y = rot_y_reg;
    assign rot_z = rot_z_reg;

endmodule

@@ hdl/point_axis_rotator_core.sv @@
// ============================================================================
// point_axis_rotator_core: rotate two 3D points about the x or y axis
// Two lanes rotate the two points of an item by +/- the configured step
// angle; the sine and cosine come from a CORDIC run on each angle write.
// ============================================================================
//
// Channel   Dir  Handshake              Payload (low bit first)
// --------  ---  ---------------------  -------------------------------------
// s_axis    in   tvalid/tready          tuser: command[2:0]
//                                       tdata: first_x, first_y, first_z,
//                                              second_x, second_y, second_z
// m_axis    out  tvalid/tready          tdata: rot_first_x .. rot_second_z
// cfg       in   cfg_wr_en (no stall)   cfg_wr_data: step_angle (Q2.13)
//
// Pipeline: one item a cycle unless m_axis or an angle write stalls it; two
//   register stages (products, then rounded and saturated result). Products
//   load as the item is taken, the result when the output stage can advance.
// Angle write: the trig unit folds the angle by 2pi one step a cycle (one
//   step at 13 fraction bits, up to five at 10) plus a half-turn step, then
//   runs 17 CORDIC steps; s_axis_tready stays low for those cycles.
// Stalls: each stage advances whenever the next one is empty or moving, so
//   bubbles close up and an item is taken while a result waits on m_axis.
// Reset: pipeline empty, angle zero (points pass through unchanged).
// ============================================================================
module point_axis_rotator_core #(
    parameter int COORD_WIDTH     = 24,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_wr_en,
    input  logic [15:0]                              cfg_wr_data,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: first_x, first_y, first_z, second_x, second_y, second_z, pad
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    // tuser: command
    input  logic [2:0]                               s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // tdata: rot_first_x, rot_first_y, rot_first_z,
    //        rot_second_x, rot_second_y, rot_second_z, pad
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0]       m_axis_tdata
);
    import pav_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int DATA_W = ((6*COORD_WIDTH+7)/8)*8;
    localparam int PAD_W  = DATA_W - 6*CW;

    trig_t                    trig;
    lane_mode_t               mode;
    logic signed [TRIG_W-1:0] sin_eff;
    logic                     sin_neg;

    logic mul_valid_reg, mul_valid_next;
    logic out_valid_reg, out_valid_next;
    logic adv_out, adv_mul, take_in, load_out;

    logic signed [CW-1:0] r_fx, r_fy, r_fz, r_sx, r_sy, r_sz;

    pav_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .trig        (trig)
    );

    // Decode the command: axis and sign of the step; a zero angle or an
    // unknown command passes the points straight through.
    always_comb
    begin
        sin_neg = 1'b0;
        unique case (s_axis_tuser) inside
            CMD_X_POS:
            begin
                mode = MODE_ROT_X;
            end
            CMD_X_NEG:
            begin
                mode    = MODE_ROT_X;
                sin_neg = 1'b1;
            end
            CMD_Y_NEG:
            begin
                mode    = MODE_ROT_Y;
                sin_neg = 1'b1;
            end
            CMD_Y_POS:
            begin
                mode = MODE_ROT_Y;
            end
            default:
            begin
                mode = MODE_PASS;
            end
        endcase
        if (trig.zero)
        begin
            mode = MODE_PASS;
        end
        sin_eff = sin_neg ? -trig.sin_q : trig.sin_q;
    end

    // Stage control: advance a stage when the next one is free or moving on
    always_comb
    begin
        adv_out       = !out_valid_reg || m_axis_tready;
        adv_mul       = !mul_valid_reg || adv_out;
        s_axis_tready = adv_mul && !trig.busy;
        take_in       = s_axis_tvalid && s_axis_tready;
        load_out      = mul_valid_reg && adv_out;

        mul_valid_next = adv_mul ? take_in : mul_valid_reg;
        out_valid_next = adv_out ? mul_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    pav_lane #(
        .COORD_WIDTH (CW)
    ) u_lane_first (
        .clk      (clk),
        .load_mul (take_in),
        .load_out (load_out),
        .mode     (mode),
        .cos_q    (trig.cos_q),
        .sin_q    (sin_eff),
        .x        (signed'(s_axis_tdata[0*CW +: CW])),
        .y        (signed'(s_axis_tdata[1*CW +: CW])),
        .z        (signed'(s_axis_tdata[2*CW +: CW])),
        .rot_x    (r_fx),
        .rot_y    (r_fy),
        .rot_z    (r_fz)
    );

    pav_lane #(
        .COORD_WIDTH (CW)
    ) u_lane_second (
        .clk      (clk),
        .load_mul (take_in),
        .load_out (load_out),
        .mode     (mode),
        .cos_q    (trig.cos_q),
        .sin_q    (sin_eff),
        .x        (signed'(s_axis_tdata[3*CW +: CW])),
        .y        (signed'(s_axis_tdata[4*CW +: CW])),
        .z        (signed'(s_axis_tdata[5*CW +: CW])),
        .rot_x    (r_sx),
        .rot_y    (r_sy),
        .rot_z    (r_sz)
    );

    // Merge the two lanes into one result item, zero padding on top
    generate
        if (PAD_W > 0)
        begin : g_pad
            assign m_axis_tdata[DATA_W-1 -: PAD_W] = '0;
        end
    endgenerate

    assign m_axis_tdata[6*CW-1:0] = {r_sz, r_sy, r_sx, r_fz, r_fy, r_fx};
    assign m_axis_tvalid          = out_valid_reg;

endmodule

@@ tb/tb_point_axis_rotator_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_point_axis_rotator_core: self-checking bench for the point axis rotator
// Streams point pairs with every command through a range of step angles,
// predicts each rotated pair with an independent fixed-point CORDIC and
// rotation model, and checks each output item field by field, in order.
// ============================================================================
module tb_point_axis_rotator_core;

    import pav_pkg::*;

    localparam int CW         = 24;
    localparam int ANGLE_FRAC = 13;
    localparam int TDATA_W    = ((6 * CW + 7) / 8) * 8;

    localparam logic [CW-1:0] COORD_MAX = CW'((1 << (CW - 1)) - 1);
    localparam logic [CW-1:0] COORD_MIN = CW'(1 << (CW - 1));

    // One input item: the command and six coordinates, first_x in pt[0]
    typedef struct packed {
        logic [2:0]           command;
        logic [5:0][CW-1:0]   pt;
    } point_pair_t;

    typedef logic [5:0][CW-1:0] rotated_pair_t;

    logic               clk;
    logic               rst_n         = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [15:0]        cfg_wr_data   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    // tdata: first_x, first_y, first_z, second_x, second_y, second_z
    logic [TDATA_W-1:0] s_axis_tdata  = '0;
    // tuser: command
    logic [2:0]         s_axis_tuser  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // tdata: rot_first_x, rot_first_y, rot_first_z,
    //        rot_second_x, rot_second_y, rot_second_z
    logic [TDATA_W-1:0] m_axis_tdata;

    point_axis_rotator_core #(
        .COORD_WIDTH     (CW),
        .ANGLE_FRAC_BITS (ANGLE_FRAC)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Rotation predictor
    // ------------------------------------------------------------------------
    // Sine and cosine of the current step angle in Q16, refreshed on each
    // angle write; reset leaves the angle at zero and cosine at one.
    logic [15:0] trig_angle = '0;
    longint      trig_sin   = 0;
    longint      trig_cos   = Q_ONE;

    // atan(2^-i) in Q16
    longint arctan_steps [CORDIC_STEPS] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
        128, 64, 32, 16, 8, 4, 2, 1
    };

    string coord_name [6] = '{
        "rot_first_x", "rot_first_y", "rot_first_z",
        "rot_second_x", "rot_second_y", "rot_second_z"
    };

    function automatic void load_trig(input logic [15:0] angle);
        longint a;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        int     i;
        // bring the angle to Q16
        a = longint'($signed(angle)) * (longint'(1) << (16 - ANGLE_FRAC));
        x = CORDIC_GAIN;
        y = 0;
        flip = 1'b0;
        // fold into [-pi, pi], then into [-pi/2, pi/2] by a half turn
        while (a > Q_PI)
            a -= Q_TWO_PI;
        while (a < -Q_PI)
            a += Q_TWO_PI;
        if (a > Q_HALF_PI)
        begin
            a -= Q_PI;
            flip = 1'b1;
        end
        else if (a < -Q_HALF_PI)
        begin
            a += Q_PI;
            flip = 1'b1;
        end
        // arithmetic shifts on signed values round towards minus infinity
        for (i = 0; i < CORDIC_STEPS; i++)
        begin
            if (a >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                a -= arctan_steps[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                a += arctan_steps[i];
            end
            x = nx;
        end
        trig_cos   = flip ? -x : x;
        trig_sin   = flip ? -y : y;
        trig_angle = angle;
    endfunction

    // Round half up out of Q16, then clamp to the coordinate range
    function automatic logic [CW-1:0] round_saturate(input longint acc);
        longint r;
        r = (acc + 32768) >>> 16;
        if (r > longint'($signed({1'b0, COORD_MAX})))
            r = longint'($signed({1'b0, COORD_MAX}));
        if (r < longint'($signed(COORD_MIN)))
            r = longint'($signed(COORD_MIN));
        return r[CW-1:0];
    endfunction

    function automatic rotated_pair_t rotate_points(input point_pair_t item);
        rotated_pair_t res;
        longint        px;
        longint        py;
        longint        pz;
        longint        s;
        longint        c;
        bit            about_x;
        int            b;
        res = item.pt;
        // zero angle and unknown commands pass the points through
        if (trig_angle == '0)
            return res;
        case (item.command)
            CMD_X_POS, CMD_Y_POS: s = trig_sin;
            CMD_X_NEG, CMD_Y_NEG: s = -trig_sin;
            default:              return res;
        endcase
        c = trig_cos;
        about_x = (item.command == CMD_X_POS) || (item.command == CMD_X_NEG);
        for (b = 0; b < 6; b += 3)
        begin
            px = longint'($signed(item.pt[b]));
            py = longint'($signed(item.pt[b + 1]));
            pz = longint'($signed(item.pt[b + 2]));
            if (about_x)
            begin
                res[b + 1] = round_saturate(py * c - pz * s);
                res[b + 2] = round_saturate(py * s + pz * c);
            end
            else
            begin
                res[b]     = round_saturate(px * c + pz * s);
                res[b + 2] = round_saturate(pz * c - px * s);
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Queues and counters
    // ------------------------------------------------------------------------
    point_pair_t   pending_items [$];
    rotated_pair_t expected_points [$];
    int            error_count  = 0;
    int            results_seen = 0;

    // ------------------------------------------------------------------------
    // Input driver: bursts of random length separated by random gaps; a
    // burst may run with no gap after it at all.
    // ------------------------------------------------------------------------
    point_pair_t offered    = '0;
    int          burst_left = 0;
    int          gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin : drive_items
        logic offer;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            offer = s_axis_tvalid;
            // item taken: record what the block must return for it
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_points.push_back(rotate_points(offered));
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_items.size() > 0)
                begin
                    offered = pending_items.pop_front();
                    offer = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            // hold the offered item steady until it is taken
            s_axis_tvalid <= offer;
            s_axis_tdata  <= offered.pt;
            s_axis_tuser  <= offered.command;
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: compare each result with the oldest expectation and
    // drive tready in stretches of differing stall density. Once, with plenty
    // of input still queued, hold tready low for a long stretch so that the
    // pipeline fills and back-pressures the input.
    // ------------------------------------------------------------------------
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int stretch_left = 0;
    int stall_pct    = 0;

    always @(posedge clk or negedge rst_n)
    begin : check_results
        rotated_pair_t want;
        logic          ready;
        int            f;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_points.size() == 0)
                begin
                    $display("%0t: result with none expected: expected nothing, actual %h",
                             $time, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    for (f = 0; f < 6; f++)
                    begin
                        if (m_axis_tdata[f*CW +: CW] !== want[f])
                        begin
                            $display("%0t: %s mismatch: expected %h, actual %h",
                                     $time, coord_name[f], want[f],
                                     m_axis_tdata[f*CW +: CW]);
                            error_count++;
                        end
                    end
                end
            end

            if (hold_left > 0)
            begin
                hold_left--;
                ready = 1'b0;
            end
            else if (!hold_done && results_seen >= 600 && pending_items.size() > 100)
            begin
                hold_left = 300;
                hold_done = 1'b1;
                ready = 1'b0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stretch_left = $urandom_range(1, 60);
                    case ($urandom_range(0, 2))
                        0:       stall_pct = 0;
                        1:       stall_pct = 25;
                        default: stall_pct = 75;
                    endcase
                end
                else
                    stretch_left--;
                ready = ($urandom_range(0, 99) >= stall_pct);
            end
            m_axis_tready <= ready;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_pair(input logic [2:0] cmd,
                            input logic [CW-1:0] fx, fy, fz, sx, sy, sz);
        point_pair_t p;
        p.command = cmd;
        p.pt = {sz, sy, sx, fz, fy, fx};
        pending_items.push_back(p);
    endtask

    // Mix of full-range, small, mid-range and extreme coordinates
    function automatic logic [CW-1:0] random_coord();
        case ($urandom_range(0, 4))
            0:
                return CW'(int'($urandom_range(0, 8191)) - 4096);
            1:
                return CW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            2:
                case ($urandom_range(0, 3))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return '1;
                    default: return '0;
                endcase
            default:
                return CW'($urandom);
        endcase
    endfunction

    task automatic queue_random_pairs(input int count);
        logic [2:0] cmd;
        int         n;
        for (n = 0; n < count; n++)
        begin
            // mostly real rotations; the rest take a random command code of any kind
            if ($urandom_range(0, 9) < 8)
                cmd = 3'($urandom_range(CMD_X_POS, CMD_Y_POS));
            else
                cmd = 3'($urandom);
            add_pair(cmd, random_coord(), random_coord(), random_coord(),
                     random_coord(), random_coord(), random_coord());
        end
    endtask

    // Wait until every queued item has been taken and answered
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_points.size() != 0)
            @(negedge clk);
    endtask

    // Write the angle on an idle block and refresh the predicted sine/cosine
    task automatic write_step_angle(input logic [15:0] angle);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= angle;
        load_trig(angle);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [15:0] angle_plan [11];
        int          k;
        angle_plan = '{
            16'sd25736, -16'sd25736, 16'sd32767, -16'sd32768, 16'sd12868,
            -16'sd12869, 16'sd1, -16'sd1, 16'h0000, 16'h0000, 16'h0000
        };
        // random full-range angle, then zero, then a random small angle
        angle_plan[8]  = 16'($urandom);
        angle_plan[10] = 16'(int'($urandom_range(0, 2000)) - 1000);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // angle still zero after reset: rotations must pass straight through
        add_pair(CMD_X_POS, COORD_MAX, COORD_MIN, COORD_MAX,
                 COORD_MIN, COORD_MAX, COORD_MIN);
        add_pair(CMD_Y_NEG, 24'h123456, 24'hFEDCBA, 24'h000100,
                 24'hFFFF00, 24'h7FFF00, 24'h800100);
        wait_drained();

        // roughly a quarter turn over two: every command, zeros, extremes
        // and saturation of the rotated coordinates
        write_step_angle(16'sd6434);
        for (k = 0; k < 8; k++)
        begin
            add_pair(3'(k), 24'sd256000, 24'sd512000, -24'sd768000,
                     COORD_MAX, COORD_MAX, COORD_MAX);
            add_pair(3'(k), COORD_MIN, COORD_MIN, COORD_MIN, '0, '0, '0);
        end
        add_pair(CMD_X_POS, COORD_MAX, COORD_MIN, COORD_MAX,
                 COORD_MIN, COORD_MAX, COORD_MIN);
        add_pair(CMD_Y_POS, COORD_MAX, COORD_MIN, COORD_MAX,
                 COORD_MIN, COORD_MAX, COORD_MIN);
        add_pair(CMD_X_NEG, '1, '1, '1, '1, '1, '1);
        add_pair(CMD_Y_NEG, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1);
        wait_drained();

        // random phases, one angle each, extremes and folds among them
        for (k = 0; k < 11; k++)
        begin
            write_step_angle(angle_plan[k]);
            queue_random_pairs(180);
            wait_drained();
        end

        // let the pipeline settle so any stray result is caught
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : watchdog
        #(2_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
